// ===== sv/bcp_pkg.sv =====
// Shared types, constants and helpers for the box closest point / SDF unit.
// Used by the top level, front, queue and back modules; no dependencies.
`default_nettype none

package bcp_pkg;

    localparam int AXES       = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Pipe depths of the square root and divide units
    localparam int SQ_LAT  = 32;
    localparam int DIV_LAT = 15;

    // Unit vectors are Q2.14
    localparam logic [15:0] Q14_POS = 16'h4000;
    localparam logic [15:0] Q14_NEG = 16'hC000;

    localparam logic [30:0] HALF_EXT_RESET = 31'd3276800;
    localparam logic [15:0] EPS_RESET      = 16'd7;

    typedef enum logic [1:0] {
        CFG_HALF_X  = 2'd0,
        CFG_HALF_Y  = 2'd1,
        CFG_HALF_Z  = 2'd2,
        CFG_EPSILON = 2'd3
    } bcp_cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } bcp_in_t;

    typedef struct packed {
        logic               inside_res;
        logic signed [31:0] signed_distance;
        logic signed [15:0] gradient_x;
        logic signed [15:0] gradient_y;
        logic signed [15:0] gradient_z;
        logic signed [31:0] closest_x;
        logic signed [31:0] closest_y;
        logic signed [31:0] closest_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [31:0]        surface_distance;
    } bcp_out_t;

    // Classified point, front to back
    typedef struct packed {
        logic                   in_box;
        logic signed [32:0]     mx_neg;     // min(max(q), 0)
        logic [2:0][31:0]       qc;         // max(q, 0) per axis
        logic [2:0]             gneg;       // p < 0
        logic [2:0][15:0]       gface;      // face-axis gradient
        logic [2:0][31:0]       nmag;       // |p - closest|
        logic [2:0]             nneg;       // p - closest < 0
        logic [2:0][15:0]       nface;      // face-axis normal
        logic [2:0][31:0]       closest;
    } bcp_item_t;

    typedef struct packed {
        logic      glin;                    // gradient from outside vector
        logic      nsel;                    // normal from face axis
        bcp_item_t item;
    } bcp_mid_t;

    typedef struct packed {
        logic             in_box;
        logic             glin;
        logic             nsel;
        logic [2:0]       gneg;
        logic [2:0]       nneg;
        logic [2:0][15:0] gface;
        logic [2:0][15:0] nface;
        logic [2:0][31:0] closest;
        logic [31:0]      sd;
        logic [31:0]      slen;
    } bcp_tail_t;

    function automatic logic [15:0] sign_q14(input logic is_zero, input logic is_neg);
        logic [15:0] v;
        if (is_zero)
        begin
            v = 16'h0000;
        end
        else if (is_neg)
        begin
            v = Q14_NEG;
        end
        else
        begin
            v = Q14_POS;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/box_closest_point_and_sdf_unit.sv =====
// Top level of the axis-aligned box closest point / signed distance unit.
// Depends on bcp_pkg, bcp_front, bcp_fifo and bcp_back.
//
//  channel   handshake               payload                  notes
//  -------   ---------------------   ----------------------   ----------------------------
//  point     push / full             point (bcp_in_t)         request taken on push & !full
//  result    pop / empty             result (bcp_out_t)       oldest result shown, !empty
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data      ready always high
//
// One request per cycle sustained while results are popped; the path from push to result:
// two front classify stages, the four-entry queue, square and sum stages,
// the 32-stage square root pipe, one operand stage, the 15-stage divide pipe
// and the output register. Reset clears all valid flags and reloads the box
// registers to their defaults. When the result is not popped the back pipe
// holds; the queue and front keep taking requests until the queue and front stages fill.
`default_nettype none

module box_closest_point_and_sdf_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire bcp_pkg::bcp_in_t       point,
    output logic                        empty,
    input  wire logic                   pop,
    output bcp_pkg::bcp_out_t           result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire bcp_pkg::bcp_cfg_idx_t  cfg_index,
    input  wire logic [31:0]            cfg_data
);

    import bcp_pkg::*;

    logic [2:0][30:0] ext_reg;
    logic [15:0]      eps_reg;
    logic [31:0]      eps_sq_reg;

    logic      front_valid;
    logic      front_ready;
    bcp_item_t front_item;
    logic      queue_valid;
    logic      queue_pop;
    bcp_item_t queue_item;

    assign cfg_ready = 1'b1;

    // Box registers; eps squared is kept alongside for the length tests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg[0] <= HALF_EXT_RESET;
            ext_reg[1] <= HALF_EXT_RESET;
            ext_reg[2] <= HALF_EXT_RESET;
            eps_reg    <= EPS_RESET;
            eps_sq_reg <= 32'(EPS_RESET * EPS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF_X:  ext_reg[0] <= cfg_data[30:0];
                CFG_HALF_Y:  ext_reg[1] <= cfg_data[30:0];
                CFG_HALF_Z:  ext_reg[2] <= cfg_data[30:0];
                CFG_EPSILON:
                begin
                    eps_reg    <= cfg_data[15:0];
                    eps_sq_reg <= cfg_data[15:0] * cfg_data[15:0];
                end
                default:     eps_reg <= eps_reg;
            endcase
        end
    end

    // Front: classify the point against the box
    bcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .point      (point),
        .ext        (ext_reg),
        .eps        (eps_reg),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    // Decouples front stalls from back stalls
    bcp_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_pop   (queue_pop),
        .rd_item  (queue_item)
    );

    // Back: lengths, unit vectors, result register
    bcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_pop   (queue_pop),
        .eps_sq     (eps_sq_reg),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== sv/bcp_isqrt.sv =====
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Depends on nothing; 32 stages, all advancing on en.
`default_nettype none

module bcp_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] rad,
    output logic      [31:0] root
);

    logic [33:0] rem_reg  [32];
    logic [31:0] root_reg [32];
    logic [63:0] rad_reg  [32];

    for (genvar j = 0; j < 32; j++)
    begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [35:0] trial;
        logic [35:0] cand;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rad_in  = rad_reg[j-1];
        end

        assign trial = {rem_in, rad_in[63:62]};
        assign cand  = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= cand)
                begin
                    rem_reg[j]  <= 34'(trial - cand);
                    root_reg[j] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= trial[33:0];
                    root_reg[j] <= {root_in[30:0], 1'b0};
                end
                rad_reg[j] <= {rad_in[61:0], 2'b00};
            end
        end
    end

    assign root = root_reg[31];

endmodule

`default_nettype wire

// ===== sv/bcp_udiv.sv =====
// Pipelined restoring divider: 46-bit numerator over 32-bit divisor, 15-bit quotient.
// Quotient must fit 15 bits; one quotient bit per stage, 15 stages on en.
`default_nettype none

module bcp_udiv (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [45:0] num,
    input  wire logic [31:0] den,
    output logic      [14:0] quo
);

    logic [45:0] rem_reg [15];
    logic [31:0] den_reg [15];
    logic [14:0] quo_reg [15];

    for (genvar k = 0; k < 15; k++)
    begin : g_stage
        localparam int SH = 14 - k;
        logic [45:0] rem_in;
        logic [31:0] den_in;
        logic [14:0] quo_in;
        logic [45:0] shifted;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = {14'b0, den_in} << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= shifted)
                begin
                    rem_reg[k] <= rem_in - shifted;
                    quo_reg[k] <= {quo_in[13:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    quo_reg[k] <= {quo_in[13:0], 1'b0};
                end
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[14];

endmodule

`default_nettype wire

// ===== sv/bcp_front.sv =====
// Front end: takes query points and classifies them against the box in two stages.
// Depends on bcp_pkg.
`default_nettype none

module bcp_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire bcp_pkg::bcp_in_t        point,
    input  wire logic [2:0][30:0]        ext,
    input  wire logic [15:0]             eps,
    output logic                         item_valid,
    input  wire logic                    item_ready,
    output bcp_pkg::bcp_item_t           item
);

    import bcp_pkg::*;

    logic               f1_valid_reg;
    logic signed [31:0] f1_p_reg    [AXES];
    logic signed [32:0] f1_q_reg    [AXES];
    logic [AXES-1:0]    f1_near_reg;
    logic               f2_valid_reg;
    bcp_item_t          item_reg;
    bcp_item_t          item_next;

    logic               f1_ready;
    logic               f2_ready;
    logic signed [31:0] pv [AXES];
    logic [31:0]        ap [AXES];
    logic signed [32:0] qv [AXES];
    logic [AXES-1:0]    near;

    assign f2_ready = !f2_valid_reg || item_ready;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign full     = !f1_ready;

    // Stage 1: |p|, q = |p| - e, near-face test
    always_comb
    begin
        pv[0] = point.point_x;
        pv[1] = point.point_y;
        pv[2] = point.point_z;
        for (int i = 0; i < AXES; i++)
        begin
            ap[i]   = pv[i][31] ? 32'(~pv[i] + 32'sd1) : 32'(pv[i]);
            qv[i]   = $signed(33'({1'b0, ap[i]}) - 33'({2'b00, ext[i]}));
            near[i] = (33'({1'b0, ap[i]}) + 33'(eps)) >= 33'({2'b00, ext[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (f1_ready)
            begin
                f1_valid_reg <= push;
            end
            if (f2_ready)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_ready && push)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                f1_p_reg[i] <= pv[i];
                f1_q_reg[i] <= qv[i];
            end
            f1_near_reg <= near;
        end
        if (f2_ready)
        begin
            item_reg <= item_next;
        end
    end

    // Stage 2: nearest face, closest point, offset vector and face fallbacks
    always_comb
    begin
        logic [AXES-1:0]    ax;
        logic [AXES-1:0]    outs;
        logic [AXES-1:0]    pushed;
        logic [AXES-1:0]    pneg;
        logic [AXES-1:0]    pzero;
        logic [AXES-1:0]    ncond;
        logic [AXES-1:0]    czero;
        logic [AXES-1:0]    cneg;
        logic signed [32:0] mx;
        logic [31:0]        e_pos;
        logic [31:0]        e_neg;
        logic               in_box;

        ax[0] = (f1_q_reg[0] >= f1_q_reg[1]) && (f1_q_reg[0] >= f1_q_reg[2]);
        ax[1] = !ax[0] && (f1_q_reg[1] >= f1_q_reg[0]) && (f1_q_reg[1] >= f1_q_reg[2]);
        ax[2] = !ax[0] && !ax[1];
        mx    = ax[0] ? f1_q_reg[0] : (ax[1] ? f1_q_reg[1] : f1_q_reg[2]);

        for (int i = 0; i < AXES; i++)
        begin
            outs[i]  = !f1_q_reg[i][32] && (f1_q_reg[i] != 33'sd0);
            pneg[i]  = f1_p_reg[i][31];
            pzero[i] = (f1_p_reg[i] == 32'sd0);
        end
        in_box = (outs == '0);

        item_next        = '0;
        item_next.in_box = in_box;
        item_next.mx_neg = mx[32] ? mx : 33'sd0;

        for (int i = 0; i < AXES; i++)
        begin
            pushed[i] = in_box && ax[i];
            e_pos     = {1'b0, ext[i]};
            e_neg     = 32'(32'd0 - e_pos);

            item_next.qc[i]    = outs[i] ? f1_q_reg[i][31:0] : 32'd0;
            item_next.gneg[i]  = pneg[i];
            item_next.gface[i] = ax[i] ? sign_q14(pzero[i], pneg[i]) : 16'h0000;

            if (pushed[i])
            begin
                item_next.closest[i] = (!pneg[i] && !pzero[i]) ? e_pos : e_neg;
                item_next.nmag[i]    = 32'(33'sd0 - f1_q_reg[i]);
            end
            else if (outs[i])
            begin
                item_next.closest[i] = pneg[i] ? e_neg : e_pos;
                item_next.nmag[i]    = f1_q_reg[i][31:0];
            end
            else
            begin
                item_next.closest[i] = f1_p_reg[i];
                item_next.nmag[i]    = 32'd0;
            end
            item_next.nneg[i] = in_box ? (!pneg[i] && !pzero[i]) : pneg[i];

            ncond[i] = outs[i] || pushed[i] || f1_near_reg[i];
            czero[i] = (pushed[i] || outs[i]) ? (ext[i] == 31'd0) : pzero[i];
            cneg[i]  = pushed[i] ? !(!pneg[i] && !pzero[i]) : pneg[i];
        end

        // first axis whose closest coordinate sits within epsilon of its face, else the z axis
        if (ncond[0])
        begin
            item_next.nface[0] = sign_q14(czero[0], cneg[0]);
        end
        else if (ncond[1])
        begin
            item_next.nface[1] = sign_q14(czero[1], cneg[1]);
        end
        else
        begin
            item_next.nface[2] = sign_q14(czero[2], cneg[2]);
        end
    end

    assign item_valid = f2_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== sv/bcp_fifo.sv =====
// Short request queue between the front and back halves.
// Depends on bcp_pkg for the item type and depth.
`default_nettype none

module bcp_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    input  wire bcp_pkg::bcp_item_t wr_item,
    output logic                    rd_valid,
    input  wire logic               rd_pop,
    output bcp_pkg::bcp_item_t      rd_item
);

    import bcp_pkg::*;

    bcp_item_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + 1'b1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + 1'b1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= FIFO_CW'(count_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= FIFO_CW'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bcp_back.sv =====
// Back end: squares, square roots, unit-vector divides and result assembly.
// Depends on bcp_pkg, bcp_isqrt and bcp_udiv. Whole pipe advances together.
`default_nettype none

module bcp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bcp_pkg::bcp_item_t item,
    input  wire logic               item_valid,
    output logic                    item_pop,
    input  wire logic [31:0]        eps_sq,
    output logic                    empty,
    input  wire logic               pop,
    output bcp_pkg::bcp_out_t       result
);

    import bcp_pkg::*;

    logic adv;

    logic            b0_valid_reg;
    bcp_item_t       b0_item_reg;
    logic [63:0]     sqq_reg [AXES];
    logic [63:0]     sqn_reg [AXES];
    logic            b1_valid_reg;
    bcp_item_t       b1_item_reg;
    logic [63:0]     sumo_reg;
    logic [63:0]     sums_reg;

    logic [SQ_LAT-1:0]  side_valid_reg;
    bcp_mid_t           side_reg [SQ_LAT];
    logic [DIV_LAT:0]   tail_valid_reg;
    bcp_tail_t          tail_reg [DIV_LAT+1];
    logic [45:0]        num_reg  [6];
    logic [31:0]        den_reg  [6];

    logic        out_valid_reg;
    bcp_out_t    result_reg;
    bcp_out_t    result_next;

    bcp_mid_t    mid_in;
    bcp_mid_t    mid_out;
    bcp_tail_t   tail_in;
    logic [31:0] olen;
    logic [31:0] slen;
    logic [14:0] quo [6];

    assign adv      = !out_valid_reg || pop;
    assign item_pop = adv && item_valid;
    assign empty    = !out_valid_reg;
    assign result   = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg   <= 1'b0;
            b1_valid_reg   <= 1'b0;
            side_valid_reg <= '0;
            tail_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            b0_valid_reg   <= item_valid;
            b1_valid_reg   <= b0_valid_reg;
            side_valid_reg <= {side_valid_reg[SQ_LAT-2:0], b1_valid_reg};
            tail_valid_reg <= {tail_valid_reg[DIV_LAT-1:0], side_valid_reg[SQ_LAT-1]};
            out_valid_reg  <= tail_valid_reg[DIV_LAT];
        end
    end

    // Squares, then the two sums of squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_item_reg <= item;
            for (int i = 0; i < AXES; i++)
            begin
                sqq_reg[i] <= item.qc[i] * item.qc[i];
                sqn_reg[i] <= item.nmag[i] * item.nmag[i];
            end
            b1_item_reg <= b0_item_reg;
            sumo_reg    <= sqq_reg[0] + sqq_reg[1] + sqq_reg[2];
            sums_reg    <= sqn_reg[0] + sqn_reg[1] + sqn_reg[2];
        end
    end

    always_comb
    begin
        mid_in.glin = sumo_reg > {32'd0, eps_sq};
        mid_in.nsel = (sums_reg < {32'd0, eps_sq}) || (sums_reg == 64'd0);
        mid_in.item = b1_item_reg;
    end

    bcp_isqrt u_sqrt_out (
        .clk  (clk),
        .en   (adv),
        .rad  (sumo_reg),
        .root (olen)
    );

    bcp_isqrt u_sqrt_surf (
        .clk  (clk),
        .en   (adv),
        .rad  (sums_reg),
        .root (slen)
    );

    assign mid_out = side_reg[SQ_LAT-1];

    // Signed distance and divide operands once both lengths are out
    always_comb
    begin
        logic signed [33:0] sdw;

        sdw = $signed({2'b00, olen}) + $signed({mid_out.item.mx_neg[32], mid_out.item.mx_neg});

        tail_in.in_box  = mid_out.item.in_box;
        tail_in.glin    = mid_out.glin;
        tail_in.nsel    = mid_out.nsel;
        tail_in.gneg    = mid_out.item.gneg;
        tail_in.nneg    = mid_out.item.nneg;
        tail_in.gface   = mid_out.item.gface;
        tail_in.nface   = mid_out.item.nface;
        tail_in.closest = mid_out.item.closest;
        tail_in.slen    = slen;
        if (sdw > 34'sd2147483647)
        begin
            tail_in.sd = 32'h7FFF_FFFF;
        end
        else if (sdw < -34'sd2147483648)
        begin
            tail_in.sd = 32'h8000_0000;
        end
        else
        begin
            tail_in.sd = sdw[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= mid_in;
            for (int j = 1; j < SQ_LAT; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
            tail_reg[0] <= tail_in;
            for (int j = 1; j <= DIV_LAT; j++)
            begin
                tail_reg[j] <= tail_reg[j-1];
            end
            // round half up: (mag * 2^14 + len / 2) / len
            for (int i = 0; i < AXES; i++)
            begin
                num_reg[i]        <= {mid_out.item.qc[i], 14'b0} + {15'b0, olen[31:1]};
                den_reg[i]        <= olen;
                num_reg[AXES + i] <= {mid_out.item.nmag[i], 14'b0} + {15'b0, slen[31:1]};
                den_reg[AXES + i] <= slen;
            end
            result_reg <= result_next;
        end
    end

    for (genvar u = 0; u < 6; u++)
    begin : g_div
        bcp_udiv u_div (
            .clk (clk),
            .en  (adv),
            .num (num_reg[u]),
            .den (den_reg[u]),
            .quo (quo[u])
        );
    end

    always_comb
    begin
        logic [15:0] gv [AXES];
        logic [15:0] nv [AXES];
        bcp_tail_t   t;

        t = tail_reg[DIV_LAT];
        for (int i = 0; i < AXES; i++)
        begin
            if (t.glin)
            begin
                gv[i] = t.gneg[i] ? 16'(16'd0 - {1'b0, quo[i]}) : {1'b0, quo[i]};
            end
            else
            begin
                gv[i] = t.gface[i];
            end
            if (t.nsel)
            begin
                nv[i] = t.nface[i];
            end
            else
            begin
                nv[i] = t.nneg[i] ? 16'(16'd0 - {1'b0, quo[AXES + i]})
                                  : {1'b0, quo[AXES + i]};
            end
        end

        result_next.inside_res       = t.in_box;
        result_next.signed_distance  = t.sd;
        result_next.gradient_x       = gv[0];
        result_next.gradient_y       = gv[1];
        result_next.gradient_z       = gv[2];
        result_next.closest_x        = t.closest[0];
        result_next.closest_y        = t.closest[1];
        result_next.closest_z        = t.closest[2];
        result_next.normal_x         = nv[0];
        result_next.normal_y         = nv[1];
        result_next.normal_z         = nv[2];
        result_next.surface_distance = t.slen;
    end

endmodule

`default_nettype wire
